// ===== sv/countdown_timer_with_alarm_tones_core_defines.svh =====
// Assertion macros shared by the checker.
// No dependencies.
`ifndef COUNTDOWN_TIMER_WITH_ALARM_TONES_CORE_DEFINES_SVH
`define COUNTDOWN_TIMER_WITH_ALARM_TONES_CORE_DEFINES_SVH
// implication checked on every edge outside reset
`define CTA_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define CTA_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== sv/cta_pkg.sv =====
// Package for the countdown timer: types, codes and constants.
// No dependencies.
package cta_pkg;
  localparam int MelodyDepth = 64;
  localparam int MelAw = $clog2(MelodyDepth);
  localparam int MelWidth = 32;

  typedef enum logic [1:0] {MODE_SETUP = 2'd0, MODE_RUN = 2'd1,
                            MODE_TIMEUP = 2'd2, MODE_EMERG = 2'd3} mode_t;
  typedef enum logic [1:0] {PH_NOTE = 2'd0, PH_GAP = 2'd1, PH_REST = 2'd2} phase_t;
  typedef enum logic [1:0] {REQ_KEY = 2'd0, REQ_TICK = 2'd1,
                            REQ_EMERG = 2'd2, REQ_LOAD = 2'd3} req_t;
  typedef enum logic [2:0] {CFG_MS_TENTH = 3'd0, CFG_TENTHS = 3'd1, CFG_GAP = 3'd2,
                            CFG_REST = 3'd3, CFG_SIR_LO = 3'd4, CFG_SIR_HI = 3'd5,
                            CFG_SIR_STEP = 3'd6, CFG_MEL_LEN = 3'd7} cfg_idx_t;
  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_MEM_WAIT, S_NOTE, S_DIV, S_DIVWAIT, S_DISP, S_OUT
  } state_t;

  localparam logic [3:0] KeyStar = 4'd10;
  localparam logic [3:0] KeyHash = 4'd11;
  localparam logic [13:0] MaxSeconds = 14'd9999;
  localparam logic [18:0] ToneNum = 19'd312500;
  localparam logic [15:0] MinFreq = 16'd1220;

  // controller -> datapath
  typedef struct packed {
    logic load_in;   // capture input beat
    logic exec;      // apply the item
    logic note;      // finish note start with fetched entry
    logic div_start; // start tone division
    logic div_apply; // apply tone from quotient
    logic disp_apply;
    logic out_load;
  } cmd_t;
  // datapath -> controller
  typedef struct packed {
    logic need_note;
    logic need_div;
    logic div_done;
  } sts_t;
endpackage

// ===== sv/cta_ram.sv =====
// Generic single-port-write RAM with registered read.
// No dependencies.
module cta_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/cta_div.sv =====
// Serial restoring divider, one quotient bit a cycle.
// Depends on nothing outside itself.
module cta_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [18:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [18:0] quo
);
  logic [18:0] q_r, q_nxt;
  logic [16:0] r_r, r_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {r_r[15:0], q_r[18]};
    if (start) begin
      q_nxt = num;
      r_nxt = '0;
      cnt_nxt = 5'd19;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den}) begin
        r_nxt = trial - {1'b0, den};
        q_nxt = {q_r[17:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[17:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

// ===== sv/cta_ctrl.sv =====
// Controller state machine sequencing one item through the datapath.
// Depends on cta_pkg.
module cta_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_full,
  input  cta_pkg::sts_t    sts,
  output cta_pkg::cmd_t    cmd
);
  cta_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cta_pkg::S_IDLE:     if (in_valid) state_nxt = cta_pkg::S_EXEC;
      cta_pkg::S_EXEC: begin
        if (sts.need_note) state_nxt = cta_pkg::S_MEM_WAIT;
        else if (sts.need_div) state_nxt = cta_pkg::S_DIV;
        else state_nxt = cta_pkg::S_DISP;
      end
      cta_pkg::S_MEM_WAIT: state_nxt = cta_pkg::S_NOTE;
      cta_pkg::S_NOTE:
        state_nxt = sts.need_div ? cta_pkg::S_DIV : cta_pkg::S_DISP;
      cta_pkg::S_DIV:      state_nxt = cta_pkg::S_DIVWAIT;
      cta_pkg::S_DIVWAIT:  if (sts.div_done) state_nxt = cta_pkg::S_DISP;
      cta_pkg::S_DISP:     state_nxt = cta_pkg::S_OUT;
      cta_pkg::S_OUT:      if (!out_full) state_nxt = cta_pkg::S_IDLE;
      default:             state_nxt = cta_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      cta_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load_in = in_valid;
      end
      cta_pkg::S_EXEC:     cmd.exec = 1'b1;
      cta_pkg::S_NOTE:     cmd.note = 1'b1;
      cta_pkg::S_DIV:      cmd.div_start = 1'b1;
      cta_pkg::S_DIVWAIT:  cmd.div_apply = sts.div_done;
      cta_pkg::S_DISP:     cmd.disp_apply = 1'b1;
      cta_pkg::S_OUT:      cmd.out_load = !out_full;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cta_pkg::S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

// ===== sv/cta_dp.sv =====
// Datapath: timer state, melody store, tone divider, output register.
// Depends on cta_pkg, cta_ram, cta_div.
module cta_dp (
  input  logic          clk,
  input  logic          rst_n,
  input  cta_pkg::cmd_t cmd,
  output cta_pkg::sts_t sts,
  output logic          out_full,
  input  logic [1:0]    in_req_type,
  input  logic [3:0]    in_key_code,
  input  logic [5:0]    in_entry_index,
  input  logic [15:0]   in_entry_freq_hz,
  input  logic [15:0]   in_entry_duration_ms,
  input  logic          cfg_valid,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_mode,
  output logic [13:0]   out_seconds_left,
  output logic [7:0]    out_minutes_shown,
  output logic [5:0]    out_seconds_shown,
  output logic [7:0]    out_tone_period,
  output logic [6:0]    out_tone_duty
);
  // config registers
  logic [9:0]  ms_tenth_r;
  logic [3:0]  tenths_r;
  logic [15:0] gap_r, rest_r, sir_lo_r, sir_hi_r, sir_step_r;
  logic [6:0]  mel_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_tenth_r <= 10'd100;
      tenths_r <= 4'd10;
      gap_r <= 16'd30;
      rest_r <= 16'd1000;
      sir_lo_r <= 16'd1500;
      sir_hi_r <= 16'd2500;
      sir_step_r <= 16'd400;
      mel_len_r <= 7'd62;
    end else if (cfg_valid) begin
      unique case (cta_pkg::cfg_idx_t'(cfg_index))
        cta_pkg::CFG_MS_TENTH: ms_tenth_r <= cfg_data[9:0];
        cta_pkg::CFG_TENTHS:   tenths_r <= cfg_data[3:0];
        cta_pkg::CFG_GAP:      gap_r <= cfg_data;
        cta_pkg::CFG_REST:     rest_r <= cfg_data;
        cta_pkg::CFG_SIR_LO:   sir_lo_r <= cfg_data;
        cta_pkg::CFG_SIR_HI:   sir_hi_r <= cfg_data;
        cta_pkg::CFG_SIR_STEP: sir_step_r <= cfg_data;
        cta_pkg::CFG_MEL_LEN:  mel_len_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // captured input beat
  logic [1:0]  req_r;
  logic [3:0]  key_r;
  logic [5:0]  idx_r;
  logic [31:0] ent_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      req_r <= in_req_type;
      key_r <= in_key_code;
      idx_r <= in_entry_index;
      ent_r <= {in_entry_freq_hz, in_entry_duration_ms};
    end
  end

  // timer state
  cta_pkg::mode_t  mode_r, mode_nxt;
  cta_pkg::phase_t ph_r, ph_nxt;
  logic [13:0] secs_r, secs_nxt;
  logic [9:0]  ms_r, ms_nxt, ms_inc;
  logic [3:0]  tn_r, tn_nxt, tn_inc;
  logic [6:0]  pos_r, pos_nxt;
  logic [15:0] left_r, left_nxt;
  logic        hi_r, hi_nxt;
  logic [7:0]  per_r, per_nxt;
  logic [6:0]  duty_r, duty_nxt;
  logic        need_note_r, need_note_nxt, need_div_r, need_div_nxt;
  logic [15:0] freq_r, freq_nxt;
  logic [6:0]  eff_len;
  logic [17:0] mul10;

  // melody store
  logic [31:0] rdata;
  logic        mem_we;
  assign mem_we = cmd.exec && (req_r == cta_pkg::REQ_LOAD);
  cta_ram #(.Width(cta_pkg::MelWidth), .Depth(cta_pkg::MelodyDepth)) u_ram (
    .clk(clk), .we(mem_we), .waddr(idx_r[cta_pkg::MelAw-1:0]), .wdata(ent_r),
    .raddr(pos_r[cta_pkg::MelAw-1:0]), .rdata(rdata)
  );

  // tone divider: 312500 / f
  logic        dv_start;
  logic [18:0] dv_num, dv_quo;
  logic [15:0] dv_den;
  logic        dv_done;
  assign dv_start = cmd.div_start;
  assign dv_num = cta_pkg::ToneNum;
  assign dv_den = freq_r;
  cta_div u_div (.clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num),
                 .den(dv_den), .done(dv_done), .quo(dv_quo));

  always_comb begin
    eff_len = mel_len_r;
    if (eff_len == 7'd0) eff_len = 7'd1;
    if (eff_len > 7'(cta_pkg::MelodyDepth)) eff_len = 7'(cta_pkg::MelodyDepth);
  end

  assign mul10 = {1'b0, secs_r, 3'd0} + {3'd0, secs_r, 1'b0} + {14'd0, key_r};
  assign ms_inc = ms_r + 10'd1;
  assign tn_inc = tn_r + 4'd1;

  // item execution; tone requests set freq and flags, finished later
  always_comb begin
    mode_nxt = mode_r; ph_nxt = ph_r; secs_nxt = secs_r; ms_nxt = ms_r;
    tn_nxt = tn_r; pos_nxt = pos_r; left_nxt = left_r; hi_nxt = hi_r;
    per_nxt = per_r; duty_nxt = duty_r; freq_nxt = freq_r;
    need_note_nxt = need_note_r; need_div_nxt = need_div_r;
    if (cmd.exec) begin
      need_note_nxt = 1'b0;
      need_div_nxt = 1'b0;
      unique case (cta_pkg::req_t'(req_r))
        cta_pkg::REQ_KEY: begin
          if (mode_r == cta_pkg::MODE_SETUP) begin
            if (key_r <= 4'd9) begin
              secs_nxt = (mul10 > {4'd0, cta_pkg::MaxSeconds}) ? cta_pkg::MaxSeconds
                                                                  : mul10[13:0];
            end else if (key_r == cta_pkg::KeyHash) begin
              if (secs_r != 14'd0) begin
                mode_nxt = cta_pkg::MODE_RUN; tn_nxt = '0; ms_nxt = '0;
              end
            end else if (key_r == cta_pkg::KeyStar) begin
              secs_nxt = '0;
            end
          end else if (mode_r != cta_pkg::MODE_RUN && key_r == cta_pkg::KeyStar) begin
            mode_nxt = cta_pkg::MODE_SETUP;
            duty_nxt = '0;
          end
        end
        cta_pkg::REQ_TICK: begin
          if (mode_r == cta_pkg::MODE_RUN) begin
            ms_nxt = ms_inc;
            if (ms_inc >= ms_tenth_r) begin
              ms_nxt = '0;
              tn_nxt = tn_inc;
              if (tn_inc >= tenths_r) begin
                tn_nxt = '0;
                if (secs_r != 14'd0) secs_nxt = secs_r - 14'd1;
              end
            end
            if (secs_nxt == 14'd0) begin
              mode_nxt = cta_pkg::MODE_TIMEUP;
              pos_nxt = '0;
              need_note_nxt = 1'b1;
            end
          end else if (mode_r != cta_pkg::MODE_SETUP) begin
            if (left_r > 16'd1) begin
              left_nxt = left_r - 16'd1;
            end else if (mode_r == cta_pkg::MODE_TIMEUP) begin
              unique case (ph_r)
                cta_pkg::PH_NOTE: begin
                  ph_nxt = cta_pkg::PH_GAP; left_nxt = gap_r; duty_nxt = '0;
                end
                cta_pkg::PH_GAP: begin
                  pos_nxt = pos_r + 7'd1;
                  if (pos_nxt >= eff_len) begin
                    ph_nxt = cta_pkg::PH_REST; left_nxt = rest_r; duty_nxt = '0;
                  end else begin
                    need_note_nxt = 1'b1;
                  end
                end
                default: begin
                  pos_nxt = '0;
                  need_note_nxt = 1'b1;
                end
              endcase
            end else begin
              hi_nxt = !hi_r;
              left_nxt = sir_step_r;
              freq_nxt = hi_r ? sir_lo_r : sir_hi_r;
              need_div_nxt = 1'b1;
            end
          end
        end
        cta_pkg::REQ_EMERG: begin
          if (mode_r != cta_pkg::MODE_EMERG) begin
            mode_nxt = cta_pkg::MODE_EMERG; secs_nxt = '0; ms_nxt = '0; tn_nxt = '0;
            hi_nxt = 1'b0; left_nxt = sir_step_r; freq_nxt = sir_lo_r;
            need_div_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // fetched entry starts a note
    if (cmd.note) begin
      ph_nxt = cta_pkg::PH_NOTE;
      left_nxt = rdata[15:0];
      freq_nxt = rdata[31:16];
      need_div_nxt = 1'b1;
    end
    // low frequency only mutes; else take quotient
    if (cmd.div_start && freq_r < cta_pkg::MinFreq) begin
      duty_nxt = '0;
    end
    if (cmd.div_apply && freq_r >= cta_pkg::MinFreq) begin
      per_nxt = (dv_quo - 19'd1 > 19'd255) ? 8'd255 : 8'(dv_quo - 19'd1);
      duty_nxt = per_nxt[7:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= cta_pkg::MODE_SETUP; ph_r <= cta_pkg::PH_NOTE;
      secs_r <= '0; ms_r <= '0; tn_r <= '0; pos_r <= '0; left_r <= '0;
      hi_r <= 1'b0; per_r <= 8'd255; duty_r <= '0; freq_r <= '0;
      need_note_r <= 1'b0; need_div_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt; ph_r <= ph_nxt; secs_r <= secs_nxt; ms_r <= ms_nxt;
      tn_r <= tn_nxt; pos_r <= pos_nxt; left_r <= left_nxt; hi_r <= hi_nxt;
      per_r <= per_nxt; duty_r <= duty_nxt; freq_r <= freq_nxt;
      need_note_r <= need_note_nxt; need_div_r <= need_div_nxt;
    end
  end

  assign sts.need_note = need_note_nxt;
  assign sts.need_div = need_div_nxt;
  assign sts.div_done = dv_done;

  // minutes/seconds split: x/60 = (x * 17477) >> 20, exact for x below 23831
  logic [28:0] min_prod;
  logic [7:0]  min_calc;
  logic [13:0] sec_calc;
  assign min_prod = {15'd0, secs_r} * 29'd17477;
  assign min_calc = min_prod[27:20];
  assign sec_calc = secs_r - {6'd0, min_calc} * 14'd60;

  // display values and output register
  logic [7:0] min_r;
  logic [5:0] sec_r;
  always_ff @(posedge clk) begin
    if (cmd.disp_apply) begin
      min_r <= min_calc;
      sec_r <= sec_calc[5:0];
    end
  end

  logic vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (cmd.out_load) vld_r <= 1'b1;
    else if (!out_stall) vld_r <= 1'b0;
    if (cmd.out_load) begin
      out_mode <= mode_r;
      out_seconds_left <= secs_r;
      out_minutes_shown <= min_r;
      out_seconds_shown <= sec_r;
      out_tone_period <= per_r;
      out_tone_duty <= duty_r;
    end
  end
  assign out_valid = vld_r;
  assign out_full = vld_r && out_stall;
endmodule

// ===== sv/countdown_timer_with_alarm_tones_core.sv =====
// Countdown timer with PWM alarm tones. One item at a time: an accepted beat
// passes EXEC, DISP and OUT; one that sets a tone also passes DIV and DIVWAIT
// (the shared one-bit-per-cycle divider computes 312500/f), and one that also
// starts a melody note passes MEM_WAIT and NOTE first for the RAM read. The
// minutes/seconds split is a reciprocal multiply and adds no wait. The output
// register lets the next item in once the result is loaded; a stalled result
// holds off only the next item's load. Depends on cta_pkg, cta_ctrl, cta_dp.
module countdown_timer_with_alarm_tones_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [3:0]  in_key_code,
  input  logic [5:0]  in_entry_index,
  input  logic [15:0] in_entry_freq_hz,
  input  logic [15:0] in_entry_duration_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_mode,
  output logic [13:0] out_seconds_left,
  output logic [7:0]  out_minutes_shown,
  output logic [5:0]  out_seconds_shown,
  output logic [7:0]  out_tone_period,
  output logic [6:0]  out_tone_duty
);
  cta_pkg::cmd_t cmd;
  cta_pkg::sts_t sts;
  logic out_full;

  assign cfg_ready = 1'b1;

  cta_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
                   .out_full(out_full), .sts(sts), .cmd(cmd));

  cta_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .out_full(out_full),
    .in_req_type(in_req_type), .in_key_code(in_key_code),
    .in_entry_index(in_entry_index), .in_entry_freq_hz(in_entry_freq_hz),
    .in_entry_duration_ms(in_entry_duration_ms),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_mode(out_mode),
    .out_seconds_left(out_seconds_left), .out_minutes_shown(out_minutes_shown),
    .out_seconds_shown(out_seconds_shown), .out_tone_period(out_tone_period),
    .out_tone_duty(out_tone_duty)
  );
endmodule

// ===== sv/cta_checker.sv =====
// Port-level checker for the countdown timer, bound to the top level.
// Depends on cta_pkg and countdown_timer_with_alarm_tones_core_defines.svh.
`include "countdown_timer_with_alarm_tones_core_defines.svh"
module cta_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_mode,
  input logic [13:0] out_seconds_left,
  input logic [7:0]  out_minutes_shown,
  input logic [5:0]  out_seconds_shown,
  input logic [6:0]  out_tone_duty
);
  // accepted item blocks the next one at once
  `CTA_ASSERT_NXT(a_one_at_time, clk, rst_n, in_valid && !in_stall, in_stall)
  // stalled result holds
  `CTA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_seconds_left))
  // display split agrees with seconds
  `CTA_ASSERT_IMP(a_split, clk, rst_n, out_valid,
    (14'(out_minutes_shown) * 14'd60 + 14'(out_seconds_shown)) == out_seconds_left)
  // emergency mode always shows zero time
  `CTA_ASSERT_IMP(a_emerg0, clk, rst_n, out_valid && out_mode == cta_pkg::MODE_EMERG, out_seconds_left == 14'd0)
  // no tone in setup or while counting
  `CTA_ASSERT_IMP(a_quiet, clk, rst_n, out_valid && (out_mode == cta_pkg::MODE_SETUP || out_mode == cta_pkg::MODE_RUN), out_tone_duty == 7'd0)
endmodule

bind countdown_timer_with_alarm_tones_core cta_port_checker u_cta_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_mode(out_mode),
  .out_seconds_left(out_seconds_left), .out_minutes_shown(out_minutes_shown),
  .out_seconds_shown(out_seconds_shown), .out_tone_duty(out_tone_duty)
);
